// ===== rtl/three_tone_sine_pwm_synth_defines.svh =====
// Assertion macros used by the top-level synth RTL.
// In simulation they expand to concurrent assertions on clk_i, and in synthesis to nothing.
`ifndef THREE_TONE_SINE_PWM_SYNTH_DEFINES_SVH
`define THREE_TONE_SINE_PWM_SYNTH_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define TTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tts assertion failed");
// Checked at every edge, also while reset is held.
`define TTS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("tts assertion failed");
`else
`define TTS_ASSERT(label, prop)
`define TTS_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/tts_pkg.sv =====
package tts_pkg;

  // Field widths.
  localparam int unsigned STEP_W     = 20;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned SUM_W      = 9;
  localparam int unsigned NUM_VOICES = 3;

  // Configuration port.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Sine table.
  localparam int unsigned ROM_LEN   = 100;
  localparam int unsigned ROM_IDX_W = 7;

  // Divide by three for sums up to 300: (x * 171) >> 9 is exact.
  localparam int unsigned DIV3_MUL   = 171;
  localparam int unsigned DIV3_SHIFT = 9;
  localparam int unsigned DIV3_W     = 17;

  // Step reset values in hundredths of hertz.
  localparam int unsigned TONE_A_RESET = 104600;
  localparam int unsigned TONE_B_RESET = 131800;
  localparam int unsigned TONE_C_RESET = 156800;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_TONE_A = 2'd0,
    REG_TONE_B = 2'd1,
    REG_TONE_C = 2'd2
  } reg_sel_e;

  // Step update travelling from the divider to the voices.
  typedef struct packed {
    logic       vld;
    logic [1:0] sel;
  } step_wr_t;

  // floor((sin(2*pi*i/100) + 1) * 50)
  localparam logic [LEVEL_W-1:0] SINE_ROM [ROM_LEN] = '{
    7'd50, 7'd53, 7'd56, 7'd59, 7'd62, 7'd65, 7'd68, 7'd71, 7'd74, 7'd76,
    7'd79, 7'd81, 7'd84, 7'd86, 7'd88, 7'd90, 7'd92, 7'd93, 7'd95, 7'd96,
    7'd97, 7'd98, 7'd99, 7'd99, 7'd99, 7'd100, 7'd99, 7'd99, 7'd99, 7'd98,
    7'd97, 7'd96, 7'd95, 7'd93, 7'd92, 7'd90, 7'd88, 7'd86, 7'd84, 7'd81,
    7'd79, 7'd76, 7'd74, 7'd71, 7'd68, 7'd65, 7'd62, 7'd59, 7'd56, 7'd53,
    7'd50, 7'd46, 7'd43, 7'd40, 7'd37, 7'd34, 7'd31, 7'd28, 7'd25, 7'd23,
    7'd20, 7'd18, 7'd15, 7'd13, 7'd11, 7'd9, 7'd7, 7'd6, 7'd4, 7'd3,
    7'd2, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1,
    7'd2, 7'd3, 7'd4, 7'd6, 7'd7, 7'd9, 7'd11, 7'd13, 7'd15, 7'd18,
    7'd20, 7'd23, 7'd25, 7'd28, 7'd31, 7'd34, 7'd37, 7'd40, 7'd43, 7'd46
  };

  function automatic logic [LEVEL_W-1:0] sine_level(input logic [ROM_IDX_W-1:0] idx);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    if (idx < ROM_IDX_W'(ROM_LEN)) begin
      lvl = SINE_ROM[idx];
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/three_tone_sine_pwm_synth.sv =====
// Three-voice sine chord generator producing a PWM compare value.
// Input channel (in_valid_i / in_ready_o, advance_i): each beat is one tick. With
// advance_i high, all three phases step by their tone register before the levels
// are read. With advance_i low, the current levels are only reported.
// Output channel (out_valid_o / out_ready_i): one beat per input beat, in order. It
// carries duty_o, the truncated mean of the three levels, and level_a_o..level_c_o.
// Each beat passes through the phase register, the table-index multiply register and
// the output register before it is valid at the output.
// Throughput: one beat per cycle unless a step write is pending. A stalled receiver holds
// the output register; the two internal stages then fill, and in_ready_o drops.
// Configuration: an APB write to tone_a/b/c_step (byte addresses 0, 4 and 8) is split
// into table index and fraction by the divider. in_ready_o is low for the write cycle
// and while the divider is busy with it. Reads return the written step.
// Reset: phases are cleared, the steps return to 104600, 131800 and 156800, and both
// channels are empty.
`include "three_tone_sine_pwm_synth_defines.svh"

module three_tone_sine_pwm_synth import tts_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = 144000,
  parameter int unsigned TABLE_SIZE       = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  advance_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LEVEL_W-1:0]    duty_o,
  output logic [LEVEL_W-1:0]    level_a_o,
  output logic [LEVEL_W-1:0]    level_b_o,
  output logic [LEVEL_W-1:0]    level_c_o
);

  localparam int unsigned FRAC_W = $clog2(TICKS_PER_SECOND);
  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);

  logic                  cfg_wr;
  logic [1:0]            reg_sel;
  logic                  sel_known;
  logic [STEP_W-1:0]     tone_a_q, tone_b_q, tone_c_q;
  step_wr_t              div_wr, div_wr_o;
  logic                  div_busy;
  logic [IDX_W-1:0]      div_sq;
  logic [FRAC_W-1:0]     div_sr;
  logic                  cfg_busy;

  logic                  v0_q, v1_q, out_valid_q;
  logic                  en1, en2, accept, mv01, mv12;
  logic [ROM_IDX_W-1:0]  rom_a, rom_b, rom_c;
  logic [LEVEL_W-1:0]    la, lb, lc;
  logic [SUM_W-1:0]      lvl_sum;
  logic [DIV3_W-1:0]     div3_prod;
  logic [LEVEL_W-1:0]    duty_q, level_a_q, level_b_q, level_c_q;

  // Register decode. The APB port never waits.
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    prdata    = '0;
    sel_known = 1'b0;
    unique case (reg_sel)
      REG_TONE_A: begin
        prdata    = APB_DATA_W'(tone_a_q);
        sel_known = 1'b1;
      end
      REG_TONE_B: begin
        prdata    = APB_DATA_W'(tone_b_q);
        sel_known = 1'b1;
      end
      REG_TONE_C: begin
        prdata    = APB_DATA_W'(tone_c_q);
        sel_known = 1'b1;
      end
      default: begin
        prdata    = '0;
        sel_known = 1'b0;
      end
    endcase
  end

  // Keep the written step values so they can be read back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_a_q <= STEP_W'(TONE_A_RESET);
      tone_b_q <= STEP_W'(TONE_B_RESET);
      tone_c_q <= STEP_W'(TONE_C_RESET);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TONE_A: tone_a_q <= pwdata[STEP_W-1:0];
        REG_TONE_B: tone_b_q <= pwdata[STEP_W-1:0];
        REG_TONE_C: tone_c_q <= pwdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step reduction into table index and fraction.
  assign div_wr.vld = cfg_wr & sel_known;
  assign div_wr.sel = reg_sel;

  tts_step_div #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .TABLE_SIZE      (TABLE_SIZE)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (div_wr),
    .value_i(pwdata[STEP_W-1:0]),
    .busy_o (div_busy),
    .wr_o   (div_wr_o),
    .sq_o   (div_sq),
    .sr_o   (div_sr)
  );

  assign cfg_busy = cfg_wr | div_busy;

  // Pipeline flow: phase update, then index scale, then table lookup and mean.
  assign en2        = !out_valid_q | out_ready_i;
  assign en1        = !v1_q | en2;
  assign in_ready_o = (!v0_q | en1) & !cfg_busy;
  assign accept     = in_valid_i & in_ready_o;
  assign mv01       = v0_q & en1;
  assign mv12       = v1_q & en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v0_q        <= accept | (v0_q & !en1);
      v1_q        <= mv01 | (v1_q & !en2);
      out_valid_q <= mv12 | (out_valid_q & !out_ready_i);
    end
  end

  tts_voice #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .TABLE_SIZE      (TABLE_SIZE),
    .RESET_STEP      (TONE_A_RESET)
  ) u_voice_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_we_i(div_wr_o.vld && (div_wr_o.sel == REG_TONE_A)),
    .step_sq_i(div_sq),
    .step_sr_i(div_sr),
    .tick_i   (accept & advance_i),
    .load_i   (mv01),
    .rom_idx_o(rom_a)
  );

  tts_voice #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .TABLE_SIZE      (TABLE_SIZE),
    .RESET_STEP      (TONE_B_RESET)
  ) u_voice_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_we_i(div_wr_o.vld && (div_wr_o.sel == REG_TONE_B)),
    .step_sq_i(div_sq),
    .step_sr_i(div_sr),
    .tick_i   (accept & advance_i),
    .load_i   (mv01),
    .rom_idx_o(rom_b)
  );

  tts_voice #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .TABLE_SIZE      (TABLE_SIZE),
    .RESET_STEP      (TONE_C_RESET)
  ) u_voice_c (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_we_i(div_wr_o.vld && (div_wr_o.sel == REG_TONE_C)),
    .step_sq_i(div_sq),
    .step_sr_i(div_sr),
    .tick_i   (accept & advance_i),
    .load_i   (mv01),
    .rom_idx_o(rom_c)
  );

  // Table lookup and the truncated mean of the three levels.
  always_comb begin
    la        = sine_level(rom_a);
    lb        = sine_level(rom_b);
    lc        = sine_level(rom_c);
    lvl_sum   = SUM_W'(la) + SUM_W'(lb) + SUM_W'(lc);
    div3_prod = DIV3_W'(lvl_sum) * DIV3_W'(DIV3_MUL);
  end

  always_ff @(posedge clk_i) begin
    if (mv12) begin
      duty_q    <= LEVEL_W'(div3_prod >> DIV3_SHIFT);
      level_a_q <= la;
      level_b_q <= lb;
      level_c_q <= lc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign level_a_o   = level_a_q;
  assign level_b_o   = level_b_q;
  assign level_c_o   = level_c_q;

  // Checks on the delivered beat.
  logic [SUM_W-1:0] chk_sum, chk_duty3;
  logic             chk_lvl_ok, chk_mean_ok;
  assign chk_sum     = SUM_W'(level_a_o) + SUM_W'(level_b_o) + SUM_W'(level_c_o);
  assign chk_duty3   = SUM_W'(duty_o) * SUM_W'(NUM_VOICES);
  assign chk_lvl_ok  = (level_a_o <= LEVEL_W'(ROM_LEN)) && (level_b_o <= LEVEL_W'(ROM_LEN))
                       && (level_c_o <= LEVEL_W'(ROM_LEN));
  assign chk_mean_ok = (chk_duty3 <= chk_sum) && (chk_sum < chk_duty3 + SUM_W'(NUM_VOICES));

  `TTS_ASSERT(a_level_range, out_valid_o |-> chk_lvl_ok)
  `TTS_ASSERT(a_duty_mean, out_valid_o |-> chk_mean_ok)
  `TTS_ASSERT(a_step_latency, div_wr.vld |-> ##2 div_wr_o.vld)
  `TTS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

// ===== rtl/tts_step_div.sv =====
// Splits a written step into whole table indexes and a remainder in ticks:
// sq = (step / T) mod TABLE_SIZE and sr = step mod T. This is the step reduced
// modulo TABLE_SIZE * T and kept in index and fraction form. It uses three stages,
// with a constant-reciprocal multiply in each of the first two.
module tts_step_div import tts_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = 144000,
  parameter int unsigned TABLE_SIZE       = 100,
  localparam int unsigned FRAC_W = $clog2(TICKS_PER_SECOND),
  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  step_wr_t          wr_i,
  input  logic [STEP_W-1:0] value_i,
  output logic              busy_o,
  output step_wr_t          wr_o,
  output logic [IDX_W-1:0]  sq_o,
  output logic [FRAC_W-1:0] sr_o
);

  // Exact reciprocal of T for 20-bit dividends.
  localparam int unsigned     KT   = STEP_W + FRAC_W;
  localparam longint unsigned MT   =
      ((64'd1 << KT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam int unsigned     MT_W = $clog2(MT + 1);
  localparam int unsigned     PT_W = STEP_W + MT_W;
  localparam longint unsigned QMAX = ((64'd1 << STEP_W) - 1) / TICKS_PER_SECOND;
  localparam int unsigned     Q_W  = $clog2(QMAX + 2);

  // Exact reciprocal of TABLE_SIZE for Q_W-bit dividends.
  localparam int unsigned     KS   = Q_W + IDX_W;
  localparam longint unsigned MS   = ((64'd1 << KS) + TABLE_SIZE - 1) / TABLE_SIZE;
  localparam int unsigned     MS_W = $clog2(MS + 1);
  localparam int unsigned     PS_W = Q_W + MS_W;
  localparam longint unsigned FMAX = ((64'd1 << Q_W) - 1) / TABLE_SIZE;
  localparam int unsigned     F_W  = $clog2(FMAX + 2);

  step_wr_t          wr1_q, wr2_q;
  logic [STEP_W-1:0] v1_q;
  logic [Q_W-1:0]    q1_q, q2_q;
  logic [FRAC_W-1:0] sr2_q;
  logic [F_W-1:0]    f2_q;

  logic [PT_W-1:0]   prod_t;
  logic [Q_W-1:0]    q1_d;
  logic [STEP_W-1:0] qt_prod;
  logic [STEP_W-1:0] rem;
  logic [PS_W-1:0]   prod_s;
  logic [F_W-1:0]    f2_d;
  logic [Q_W-1:0]    fs_prod;
  logic [Q_W-1:0]    sq_full;

  // Stage one: quotient by T.
  always_comb begin
    prod_t = PT_W'(value_i) * PT_W'(MT);
    q1_d   = Q_W'(prod_t >> KT);
  end

  // Stage two: remainder by T, and the quotient by TABLE_SIZE.
  // The products stay below 2**STEP_W and 2**Q_W, so the truncated multiplies are exact.
  always_comb begin
    qt_prod = STEP_W'(q1_q) * STEP_W'(TICKS_PER_SECOND);
    rem     = v1_q - qt_prod;
    prod_s  = PS_W'(q1_q) * PS_W'(MS);
    f2_d    = F_W'(prod_s >> KS);
  end

  // Stage three: quotient modulo TABLE_SIZE.
  always_comb begin
    fs_prod = Q_W'(f2_q) * Q_W'(TABLE_SIZE);
    sq_full = q2_q - fs_prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr1_q <= '0;
      wr2_q <= '0;
    end else begin
      wr1_q <= wr_i;
      wr2_q <= wr1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q  <= value_i;
    q1_q  <= q1_d;
    q2_q  <= q1_q;
    sr2_q <= FRAC_W'(rem);
    f2_q  <= f2_d;
  end

  assign busy_o = wr1_q.vld | wr2_q.vld;
  assign wr_o   = wr2_q;
  assign sq_o   = IDX_W'(sq_full);
  assign sr_o   = sr2_q;

endmodule

// ===== rtl/tts_voice.sv =====
// One voice. The phase is held as a table index and a fraction in ticks, and it
// advances by the reduced step. The index is scaled onto the 100-entry sine table.
module tts_voice import tts_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = 144000,
  parameter int unsigned TABLE_SIZE       = 100,
  parameter int unsigned RESET_STEP       = 104600,
  localparam int unsigned FRAC_W = $clog2(TICKS_PER_SECOND),
  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_we_i,
  input  logic [IDX_W-1:0]     step_sq_i,
  input  logic [FRAC_W-1:0]    step_sr_i,
  input  logic                 tick_i,
  input  logic                 load_i,
  output logic [ROM_IDX_W-1:0] rom_idx_o
);

  localparam int unsigned RST_SQ = (RESET_STEP / TICKS_PER_SECOND) % TABLE_SIZE;
  localparam int unsigned RST_SR = RESET_STEP % TICKS_PER_SECOND;

  // Exact (idx * 100) / TABLE_SIZE, done as a single multiply by a constant.
  localparam int unsigned     P_W  = $clog2((TABLE_SIZE - 1) * ROM_LEN + 1);
  localparam int unsigned     KR   = P_W + IDX_W;
  localparam longint unsigned MR   = ((64'd1 << KR) + TABLE_SIZE - 1) / TABLE_SIZE;
  localparam longint unsigned CR   = ROM_LEN * MR;
  localparam int unsigned     CR_W = $clog2(CR + 1);
  localparam int unsigned     PR_W = IDX_W + CR_W;

  logic [IDX_W-1:0]     sq_q, idx_q, idx_d;
  logic [FRAC_W-1:0]    sr_q, frac_q, frac_d;
  logic [ROM_IDX_W-1:0] rom_q, rom_d;

  logic [FRAC_W:0]      frac_sum;
  logic                 carry;
  logic [IDX_W:0]       idx_sum;
  logic [PR_W-1:0]      prod_r;
  logic [PR_W-1:0]      rq;

  // Phase accumulate. The fraction carries into the index, and the index wraps at the table size.
  always_comb begin
    frac_sum = (FRAC_W+1)'(frac_q) + (FRAC_W+1)'(sr_q);
    carry    = frac_sum >= (FRAC_W+1)'(TICKS_PER_SECOND);
    frac_d   = carry ? FRAC_W'(frac_sum - (FRAC_W+1)'(TICKS_PER_SECOND))
                     : FRAC_W'(frac_sum);
    idx_sum  = (IDX_W+1)'(idx_q) + (IDX_W+1)'(sq_q) + (IDX_W+1)'(carry);
    idx_d    = (idx_sum >= (IDX_W+1)'(TABLE_SIZE))
               ? IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SIZE)) : IDX_W'(idx_sum);
  end

  // Scale the index onto the sine table, clamped to its last entry.
  always_comb begin
    prod_r = PR_W'(idx_q) * PR_W'(CR);
    rq     = prod_r >> KR;
    rom_d  = (rq >= PR_W'(ROM_LEN)) ? ROM_IDX_W'(ROM_LEN - 1) : ROM_IDX_W'(rq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q   <= IDX_W'(RST_SQ);
      sr_q   <= FRAC_W'(RST_SR);
      idx_q  <= '0;
      frac_q <= '0;
    end else begin
      if (step_we_i) begin
        sq_q <= step_sq_i;
        sr_q <= step_sr_i;
      end
      if (tick_i) begin
        idx_q  <= idx_d;
        frac_q <= frac_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rom_q <= rom_d;
    end
  end

  assign rom_idx_o = rom_q;

endmodule

// ===== verif/three_tone_sine_pwm_synth_test.sv =====
module three_tone_sine_pwm_synth_test;
  import tts_pkg::*;

  // Tick rate and table length of the synthesized chord.
  localparam int unsigned TICK_RATE       = 144000;
  localparam int unsigned SINE_STEPS      = 100;
  localparam int unsigned PHASE_WRAP      = TICK_RATE * SINE_STEPS;
  localparam logic [1:0]  REG_NONE        = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 360;
  localparam int unsigned NUM_PHASES      = 4;

  // One period of the sine, offset and scaled to 0..100.
  localparam logic [LEVEL_W-1:0] SINE_LEVELS [SINE_STEPS] = '{
    7'd50, 7'd53, 7'd56, 7'd59, 7'd62, 7'd65, 7'd68, 7'd71, 7'd74, 7'd76,
    7'd79, 7'd81, 7'd84, 7'd86, 7'd88, 7'd90, 7'd92, 7'd93, 7'd95, 7'd96,
    7'd97, 7'd98, 7'd99, 7'd99, 7'd99, 7'd100, 7'd99, 7'd99, 7'd99, 7'd98,
    7'd97, 7'd96, 7'd95, 7'd93, 7'd92, 7'd90, 7'd88, 7'd86, 7'd84, 7'd81,
    7'd79, 7'd76, 7'd74, 7'd71, 7'd68, 7'd65, 7'd62, 7'd59, 7'd56, 7'd53,
    7'd50, 7'd46, 7'd43, 7'd40, 7'd37, 7'd34, 7'd31, 7'd28, 7'd25, 7'd23,
    7'd20, 7'd18, 7'd15, 7'd13, 7'd11, 7'd9, 7'd7, 7'd6, 7'd4, 7'd3,
    7'd2, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1,
    7'd2, 7'd3, 7'd4, 7'd6, 7'd7, 7'd9, 7'd11, 7'd13, 7'd15, 7'd18,
    7'd20, 7'd23, 7'd25, 7'd28, 7'd31, 7'd34, 7'd37, 7'd40, 7'd43, 7'd46
  };

  typedef struct packed {
    logic [LEVEL_W-1:0] duty;
    logic [LEVEL_W-1:0] lvl_a;
    logic [LEVEL_W-1:0] lvl_b;
    logic [LEVEL_W-1:0] lvl_c;
  } chord_t;

  // Tracks the three voice phases and the chords still owed by the block.
  class chord_scoreboard;
    logic [STEP_W-1:0] tone_step [NUM_VOICES];
    int unsigned       voice_phase [NUM_VOICES];
    chord_t            chords_due [$];
    int unsigned       chords_seen;
    int unsigned       errors;

    function void clear();
      tone_step[0] = STEP_W'(TONE_A_RESET);
      tone_step[1] = STEP_W'(TONE_B_RESET);
      tone_step[2] = STEP_W'(TONE_C_RESET);
      foreach (voice_phase[v]) voice_phase[v] = 0;
      chords_due.delete();
      chords_seen = 0;
      errors = 0;
    endfunction

    // Writes to the unused register index leave every step alone.
    function void set_step(logic [1:0] sel, logic [APB_DATA_W-1:0] value);
      if (sel != REG_NONE) tone_step[sel] = value[STEP_W-1:0];
    endfunction

    function void note_tick(logic adv);
      chord_t      c;
      int unsigned lvl [NUM_VOICES];
      int unsigned idx;
      foreach (voice_phase[v]) begin
        if (adv) voice_phase[v] = (voice_phase[v] + tone_step[v]) % PHASE_WRAP;
        idx = (voice_phase[v] / TICK_RATE) % SINE_STEPS;
        lvl[v] = SINE_LEVELS[(idx * 100) / SINE_STEPS];
      end
      c.duty  = LEVEL_W'((lvl[0] + lvl[1] + lvl[2]) / 3);
      c.lvl_a = LEVEL_W'(lvl[0]);
      c.lvl_b = LEVEL_W'(lvl[1]);
      c.lvl_c = LEVEL_W'(lvl[2]);
      chords_due.push_back(c);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at chord %0d: %s", chords_seen, what);
      errors++;
    endtask

    task check_chord(chord_t got);
      chord_t want;
      if (chords_due.size() == 0) begin
        report_mismatch("result beat with no chord pending");
      end else begin
        want = chords_due.pop_front();
        if (got.duty != want.duty)
          report_mismatch($sformatf("duty %0d, expected %0d", got.duty, want.duty));
        if (got.lvl_a != want.lvl_a)
          report_mismatch($sformatf("level_a %0d, expected %0d", got.lvl_a, want.lvl_a));
        if (got.lvl_b != want.lvl_b)
          report_mismatch($sformatf("level_b %0d, expected %0d", got.lvl_b, want.lvl_b));
        if (got.lvl_c != want.lvl_c)
          report_mismatch($sformatf("level_c %0d, expected %0d", got.lvl_c, want.lvl_c));
      end
      chords_seen++;
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  advance_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [LEVEL_W-1:0]    duty_o;
  logic [LEVEL_W-1:0]    level_a_o;
  logic [LEVEL_W-1:0]    level_b_o;
  logic [LEVEL_W-1:0]    level_c_o;

  chord_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     cycle_count;
  reg_sel_e        tone_regs [NUM_VOICES] = '{REG_TONE_A, REG_TONE_B, REG_TONE_C};

  three_tone_sine_pwm_synth uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .advance_i   (advance_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .duty_o      (duty_o),
    .level_a_o   (level_a_o),
    .level_b_o   (level_b_o),
    .level_c_o   (level_c_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note accepted ticks before checking results so that order inside an edge never matters.
  always @(posedge clk_i) begin
    chord_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_tick(advance_i);
      if (out_valid_o && out_ready_i) begin
        got.duty  = duty_o;
        got.lvl_a = level_a_o;
        got.lvl_b = level_b_o;
        got.lvl_c = level_c_o;
        sb.check_chord(got);
      end
    end
  end

  // Offer one tick beat, possibly after some idle cycles, and wait for its acceptance.
  task automatic send_tick(input logic adv);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      advance_i  <= 1'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    advance_i  <= adv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait until every pending chord has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.chords_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] sel, input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_step(sel, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [1:0] sel);
    logic [APB_DATA_W-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = APB_DATA_W'(sb.tone_step[sel]);
    if (prdata != want)
      sb.report_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                   sel, prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // New random tone setting, with the extremes drawn often.
  task automatic pick_tones();
    logic [APB_DATA_W-1:0] val;
    foreach (tone_regs[v]) begin
      case ($urandom_range(4))
        0:       val = '0;
        1:       val = 32'd1000000;
        2:       val = {12'($urandom), 20'hFFFFF};
        3:       val = 32'(TICK_RATE * $urandom_range(7));
        default: val = $urandom;
      endcase
      apb_write(tone_regs[v], val);
    end
    if ($urandom_range(1) == 0) apb_write(REG_NONE, $urandom);
    foreach (tone_regs[v]) apb_read_check(tone_regs[v]);
  endtask

  initial begin
    int unsigned pause_at;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    advance_i      = 1'b0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    sb = new();
    sb.clear();

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset state: report at zero phase, then a few ticks at the reset tones.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
    foreach (tone_regs[v]) apb_read_check(tone_regs[v]);

    // Held voice, full-scale step with upper bits set, five table entries per tick
    // so the third voice passes the peak and the trough, and an ignored write.
    apb_write(REG_TONE_A, '0);
    apb_write(REG_TONE_B, 32'hFFFF_FFFF);
    apb_write(REG_TONE_C, 32'(TICK_RATE * 5));
    apb_write(REG_NONE, 32'hFFFF_FFFF);
    foreach (tone_regs[v]) apb_read_check(tone_regs[v]);
    for (int i = 0; i < 17; i++) send_tick(i != 5);
    wait_drained();

    // Random phases with different idling patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      pick_tones();
      pause_at = $urandom_range(ITEMS_PER_PHASE - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == pause_at) wait_drained();
        send_tick($urandom_range(99) < 80);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (sb.chords_due.size() != 0) sb.report_mismatch("chords still pending at end of run");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_step_div.sv
rtl/tts_voice.sv
rtl/three_tone_sine_pwm_synth.sv
verif/three_tone_sine_pwm_synth_test.sv
